// ===== hw/rtl/apc_pkg.sv =====
`timescale 1ns / 1ps

package apc_pkg;

    localparam int NUM_CLASSES = 21;
    localparam int CLASS_W     = 5;

    localparam logic [CLASS_W-1:0] CLASS_X = CLASS_W'(NUM_CLASSES - 1);

    localparam logic [1:0] KIND_RESIDUE = 2'd0;
    localparam logic [1:0] KIND_NEW_SEQ = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    localparam logic [7:0] CLASS_LETTERS [NUM_CLASSES] = '{
        "A", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M",
        "N", "P", "Q", "R", "S", "T", "V", "W", "Y", "X"
    };

    typedef struct packed {
        logic state_clear;
        logic sweep_write;
        logic residue_read;
        logic residue_write;
        logic query_read;
        logic walk_step;
        logic seq_bump;
        logic overflow_set;
        logic load_out;
    } apc_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic col_full;
        logic walk_last;
    } apc_status_t;

    function automatic logic [CLASS_W-1:0] letter_to_class(input logic [7:0] ch);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_X;
        for (int k = 0; k < NUM_CLASSES - 1; k++) begin
            if (CLASS_LETTERS[k] == ch) begin
                cls = CLASS_W'(k);
            end
        end
        return cls;
    endfunction

endpackage

// ===== hw/rtl/alignment_profile_consensus.sv =====
`timescale 1ns / 1ps

// Alignment profile consensus: per-column residue class counts with a consensus query.
// Input channel s_*: kind, residue letter and column; one transaction per item.
// Result channel m_*: one transaction per query item, none for other kinds.
// Counts sit in one memory row per column, all 21 classes side by side.
// Residue item: the row is read, then the incremented row is written back.
// New-sequence item: taken in the idle state. Residue past the table end: taken in the idle state, sets overflow.
// Query item: the row is read once, then the counts are scanned one class per cycle,
// and the result is loaded into the output register once that register is free.
// Clear item: all MAX_COLUMNS rows are zeroed in a sweep, one row per cycle.
// After reset the same clearing pass runs and s_ready stays low.
// The output register parts the channels: residue, new-sequence and clear items are
// taken while a result waits; a query waits at its end until the result register is
// free, so a stalled receiver holds back at most one further query.
module alignment_profile_consensus #(
    parameter int MAX_COLUMNS = 4096,
    parameter int COUNT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_residue,
    input  logic [11:0] s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_consensus_char,
    output logic [4:0]  m_consensus_class,
    output logic [15:0] m_dominant_count,
    output logic [15:0] m_sequences_seen,
    output logic [12:0] m_profile_length,
    output logic        m_column_in_range,
    output logic        m_overflowed
);

    apc_pkg::apc_cmd_t    cmd;
    apc_pkg::apc_status_t status;

    apc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    apc_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_residue         (s_residue),
        .s_column          (s_column),
        .m_consensus_char  (m_consensus_char),
        .m_consensus_class (m_consensus_class),
        .m_dominant_count  (m_dominant_count),
        .m_sequences_seen  (m_sequences_seen),
        .m_profile_length  (m_profile_length),
        .m_column_in_range (m_column_in_range),
        .m_overflowed      (m_overflowed)
    );

    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during clearing pass after reset");

    a_sweep_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == apc_pkg::KIND_CLEAR |=> !s_ready)
        else $error("input taken right after clear transaction");

    a_empty_is_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dominant_count == 16'd0 |-> m_consensus_class == apc_pkg::CLASS_X)
        else $error("zero dominant count with a class other than X");

    a_query_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == apc_pkg::KIND_QUERY |=> !s_ready)
        else $error("input taken while a query is being scanned");

endmodule

// ===== hw/rtl/apc_ctrl.sv =====
`timescale 1ns / 1ps

module apc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    output logic                  m_valid,
    input  logic                  m_ready,
    output apc_pkg::apc_cmd_t     cmd,
    input  apc_pkg::apc_status_t  status
);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_kind)
                        apc_pkg::KIND_RESIDUE: begin
                            if (status.col_full) begin
                                cmd.overflow_set = 1'b1;
                            end else begin
                                cmd.residue_read = 1'b1;
                                state_next       = ST_RMW;
                            end
                        end
                        apc_pkg::KIND_NEW_SEQ: begin
                            cmd.seq_bump = 1'b1;
                        end
                        apc_pkg::KIND_QUERY: begin
                            cmd.query_read = 1'b1;
                            state_next     = ST_WALK;
                        end
                        apc_pkg::KIND_CLEAR: begin
                            cmd.state_clear = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                cmd.residue_write = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/apc_dpath.sv =====
`timescale 1ns / 1ps

module apc_dpath #(
    parameter int MAX_COLUMNS = 4096,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  apc_pkg::apc_cmd_t     cmd,
    output apc_pkg::apc_status_t  status,
    input  logic [7:0]            s_residue,
    input  logic [11:0]           s_column,
    output logic [7:0]            m_consensus_char,
    output logic [4:0]            m_consensus_class,
    output logic [15:0]           m_dominant_count,
    output logic [15:0]           m_sequences_seen,
    output logic [12:0]           m_profile_length,
    output logic                  m_column_in_range,
    output logic                  m_overflowed
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CC_W  = $clog2(MAX_COLUMNS + 1);
    localparam int QW    = ((COL_W > 12) ? COL_W : 12) + 1;
    localparam int DW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int LW    = (CC_W > 13) ? CC_W : 13;
    localparam int RW    = (CC_W > 12) ? CC_W : 12;
    localparam int CW    = apc_pkg::CLASS_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [apc_pkg::NUM_CLASSES-1:0][COUNT_BITS-1:0] row_t;

    row_t mem [MAX_COLUMNS];
    row_t rd_data_reg;
    row_t bumped_row;
    row_t wd;

    logic             re, we;
    logic [COL_W-1:0] ra, wa;
    logic [QW-1:0]    qcol_w;

    logic [COL_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CC_W-1:0]  cur_col_reg, cur_col_next;
    logic [CC_W-1:0]  longest_reg, longest_next;
    logic [CC_W-1:0]  cur_col_inc;
    logic [15:0]      seq_total_reg, seq_total_next;
    logic             ovf_reg, ovf_next;

    logic [CW-1:0]         class_reg;
    logic [COL_W-1:0]      wr_addr_reg;
    logic [11:0]           qcol_reg;
    logic                  oob_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [CW-1:0]         cls_reg;
    logic [CW-1:0]         walk_idx_reg;
    logic [COUNT_BITS-1:0] lane;

    logic [DW-1:0] best_w;
    logic [LW-1:0] longest_w;
    logic [15:0]   dom_sat;
    logic [12:0]   plen_sat;
    logic          in_range;

    logic [7:0]  out_char_reg;
    logic [4:0]  out_class_reg;
    logic [15:0] out_dom_reg;
    logic [15:0] out_seq_reg;
    logic [12:0] out_plen_reg;
    logic        out_range_reg;
    logic        out_ovf_reg;

    assign qcol_w = QW'(s_column);
    assign lane   = rd_data_reg[walk_idx_reg];

    always_comb begin
        bumped_row = rd_data_reg;
        if (rd_data_reg[class_reg] != COUNT_MAX) begin
            bumped_row[class_reg] = rd_data_reg[class_reg] + 1'b1;
        end
    end

    assign re = cmd.residue_read || cmd.query_read;
    assign ra = cmd.query_read ? qcol_w[COL_W-1:0] : cur_col_reg[COL_W-1:0];
    assign we = cmd.sweep_write || cmd.residue_write;
    assign wa = cmd.sweep_write ? sweep_addr_reg : wr_addr_reg;
    assign wd = cmd.sweep_write ? row_t'('0) : bumped_row;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_data_reg <= mem[ra];
        end
    end

    assign cur_col_inc = cur_col_reg + 1'b1;

    always_comb begin
        sweep_addr_next = sweep_addr_reg;
        cur_col_next    = cur_col_reg;
        longest_next    = longest_reg;
        seq_total_next  = seq_total_reg;
        ovf_next        = ovf_reg;
        if (cmd.state_clear) begin
            sweep_addr_next = '0;
            cur_col_next    = '0;
            longest_next    = '0;
            seq_total_next  = '0;
            ovf_next        = 1'b0;
        end else begin
            if (cmd.sweep_write) begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            if (cmd.residue_write) begin
                cur_col_next = cur_col_inc;
                if (cur_col_inc > longest_reg) begin
                    longest_next = cur_col_inc;
                end
            end
            if (cmd.seq_bump) begin
                cur_col_next = '0;
                if (seq_total_reg != 16'hFFFF) begin
                    seq_total_next = seq_total_reg + 16'd1;
                end
            end
            if (cmd.overflow_set) begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            cur_col_reg    <= '0;
            longest_reg    <= '0;
            seq_total_reg  <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            sweep_addr_reg <= sweep_addr_next;
            cur_col_reg    <= cur_col_next;
            longest_reg    <= longest_next;
            seq_total_reg  <= seq_total_next;
            ovf_reg        <= ovf_next;
        end
    end

    // capture item fields, then walk the row one class a cycle
    always_ff @(posedge aclk) begin
        if (cmd.residue_read) begin
            class_reg   <= apc_pkg::letter_to_class(s_residue);
            wr_addr_reg <= cur_col_reg[COL_W-1:0];
        end
        if (cmd.query_read) begin
            qcol_reg     <= s_column;
            oob_reg      <= (qcol_w >= QW'(MAX_COLUMNS));
            best_reg     <= '0;
            cls_reg      <= apc_pkg::CLASS_X;
            walk_idx_reg <= '0;
        end else if (cmd.walk_step) begin
            if (!oob_reg && lane > best_reg) begin
                best_reg <= lane;
                cls_reg  <= walk_idx_reg;
            end
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
    end

    assign best_w    = DW'(best_reg);
    assign longest_w = LW'(longest_reg);
    assign dom_sat   = (best_w > DW'(16'hFFFF)) ? 16'hFFFF : best_w[15:0];
    assign plen_sat  = (longest_w > LW'(13'h1FFF)) ? 13'h1FFF : longest_w[12:0];
    assign in_range  = (RW'(qcol_reg) < RW'(longest_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_char_reg  <= apc_pkg::CLASS_LETTERS[cls_reg];
            out_class_reg <= cls_reg;
            out_dom_reg   <= dom_sat;
            out_seq_reg   <= seq_total_reg;
            out_plen_reg  <= plen_sat;
            out_range_reg <= in_range;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.sweep_done = (sweep_addr_reg == COL_W'(MAX_COLUMNS - 1));
    assign status.col_full   = (cur_col_reg >= CC_W'(MAX_COLUMNS));
    assign status.walk_last  = (walk_idx_reg == apc_pkg::CLASS_X);

    assign m_consensus_char  = out_char_reg;
    assign m_consensus_class = out_class_reg;
    assign m_dominant_count  = out_dom_reg;
    assign m_sequences_seen  = out_seq_reg;
    assign m_profile_length  = out_plen_reg;
    assign m_column_in_range = out_range_reg;
    assign m_overflowed      = out_ovf_reg;

endmodule

// ===== dv/tb_alignment_profile_consensus.sv =====
`timescale 1ns / 1ps

module tb_alignment_profile_consensus;

    localparam int MAX_COLS       = 4096;
    localparam int COUNT_MAX      = 16'hFFFF;
    localparam int RANDOM_ITEMS   = 1020;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 100;

    localparam logic [8*apc_pkg::NUM_CLASSES-1:0] CLASS_CHARS = "ACDEFGHIKLMNPQRSTVWYX";

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  residue;
        logic [11:0] column;
        logic        drain;
    } pending_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [4:0]  cls;
        logic [15:0] dom;
        logic [15:0] seqs;
        logic [12:0] plen;
        logic        in_range;
        logic        ovf;
    } consensus_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = apc_pkg::KIND_RESIDUE;
    logic [7:0]  s_residue = 8'h00;
    logic [11:0] s_column = 12'h000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_consensus_char;
    logic [4:0]  m_consensus_class;
    logic [15:0] m_dominant_count;
    logic [15:0] m_sequences_seen;
    logic [12:0] m_profile_length;
    logic        m_column_in_range;
    logic        m_overflowed;

    alignment_profile_consensus dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_residue         (s_residue),
        .s_column          (s_column),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_consensus_char  (m_consensus_char),
        .m_consensus_class (m_consensus_class),
        .m_dominant_count  (m_dominant_count),
        .m_sequences_seen  (m_sequences_seen),
        .m_profile_length  (m_profile_length),
        .m_column_in_range (m_column_in_range),
        .m_overflowed      (m_overflowed)
    );

    logic [15:0] column_counts [MAX_COLS][apc_pkg::NUM_CLASSES];
    logic [12:0] cur_column;
    logic [12:0] longest_row;
    logic [15:0] seq_total;
    logic        overflow_seen;

    pending_t   item_q[$];
    consensus_t consensus_q[$];

    int error_count     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int clears_accepted = 0;
    int queued_items    = 0;
    int gap_left        = 0;
    int burst_left      = 0;
    int rx_hold         = 0;
    int stall_cycles    = 0;
    logic [11:0] rx_cycle = '0;
    logic pause_next = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] class_char(input logic [4:0] cls);
        return CLASS_CHARS[8*(apc_pkg::NUM_CLASSES-1-cls) +: 8];
    endfunction

    function automatic logic [4:0] residue_class(input logic [7:0] ch);
        logic [4:0] cls;
        cls = apc_pkg::CLASS_X;
        for (int k = 0; k < apc_pkg::NUM_CLASSES - 1; k++) begin
            if (class_char(5'(k)) == ch) begin
                cls = 5'(k);
            end
        end
        return cls;
    endfunction

    function automatic logic [7:0] pick_residue();
        if ($urandom_range(0, 99) < 85) begin
            return class_char(5'($urandom_range(0, apc_pkg::NUM_CLASSES - 2)));
        end
        return 8'($urandom);
    endfunction

    task automatic clear_profile();
        for (int c = 0; c < MAX_COLS; c++) begin
            for (int k = 0; k < apc_pkg::NUM_CLASSES; k++) begin
                column_counts[c][k] = '0;
            end
        end
        cur_column    = '0;
        longest_row   = '0;
        seq_total     = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic absorb_item(input logic [1:0] kind, input logic [7:0] residue,
                               input logic [11:0] column);
        consensus_t  want;
        logic [4:0]  cls;
        logic [15:0] best;
        items_accepted++;
        case (kind)
            apc_pkg::KIND_RESIDUE: begin
                if (cur_column >= MAX_COLS) begin
                    overflow_seen = 1'b1;
                end else begin
                    cls = residue_class(residue);
                    if (column_counts[cur_column][cls] != COUNT_MAX) begin
                        column_counts[cur_column][cls] += 16'd1;
                    end
                    cur_column += 13'd1;
                    if (cur_column > longest_row) begin
                        longest_row = cur_column;
                    end
                end
            end
            apc_pkg::KIND_NEW_SEQ: begin
                if (seq_total != 16'hFFFF) begin
                    seq_total += 16'd1;
                end
                cur_column = '0;
            end
            apc_pkg::KIND_CLEAR: begin
                clears_accepted++;
                clear_profile();
            end
            default: begin
                best = '0;
                cls  = apc_pkg::CLASS_X;
                for (int k = 0; k < apc_pkg::NUM_CLASSES; k++) begin
                    if (column_counts[column][k] > best) begin
                        best = column_counts[column][k];
                        cls  = 5'(k);
                    end
                end
                want.ch       = class_char(cls);
                want.cls      = cls;
                want.dom      = best;
                want.seqs     = seq_total;
                want.plen     = longest_row;
                want.in_range = ({1'b0, column} < longest_row);
                want.ovf      = overflow_seen;
                consensus_q   = {consensus_q, want};
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("[%0t] ERROR %s", $time, msg);
        end
    endtask

    task automatic queue_item(input logic [1:0] kind, input logic [7:0] residue,
                              input logic [11:0] column);
        pending_t it;
        it.kind    = kind;
        it.residue = residue;
        it.column  = column;
        it.drain   = pause_next;
        pause_next = 1'b0;
        item_q     = {item_q, it};
        queued_items++;
    endtask

    always @(posedge aclk) begin : stimulus_driver
        pending_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(s_kind, s_residue, s_column);
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (item_q.size() == 0 ||
                             (item_q[0].drain && consensus_q.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    it = item_q.pop_front();
                    s_valid   <= 1'b1;
                    s_kind    <= it.kind;
                    s_residue <= it.residue;
                    s_column  <= it.column;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : receiver_stall
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                case (rx_cycle[11:10])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= 1'($urandom_range(0, 1));
                    2'd2: begin
                        if ($urandom_range(0, 7) == 0) begin
                            m_ready <= 1'b0;
                            rx_hold <= $urandom_range(4, 30);
                        end else begin
                            m_ready <= 1'b1;
                        end
                    end
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        consensus_t want;
        if (aresetn && m_valid && m_ready) begin
            if (consensus_q.size() == 0) begin
                flag_error("consensus result with no query outstanding");
            end else begin
                want = consensus_q.pop_front();
                results_checked++;
                if (m_consensus_char !== want.ch)
                    flag_error($sformatf("consensus_char got %02h want %02h",
                                         m_consensus_char, want.ch));
                if (m_consensus_class !== want.cls)
                    flag_error($sformatf("consensus_class got %0d want %0d",
                                         m_consensus_class, want.cls));
                if (m_dominant_count !== want.dom)
                    flag_error($sformatf("dominant_count got %0d want %0d",
                                         m_dominant_count, want.dom));
                if (m_sequences_seen !== want.seqs)
                    flag_error($sformatf("sequences_seen got %0d want %0d",
                                         m_sequences_seen, want.seqs));
                if (m_profile_length !== want.plen)
                    flag_error($sformatf("profile_length got %0d want %0d",
                                         m_profile_length, want.plen));
                if (m_column_in_range !== want.in_range)
                    flag_error($sformatf("column_in_range got %0b want %0b",
                                         m_column_in_range, want.in_range));
                if (m_overflowed !== want.ovf)
                    flag_error($sformatf("overflowed got %0b want %0b",
                                         m_overflowed, want.ovf));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired, no transaction for %0d cycles",
                     $time, stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus_plan
        int random_start;
        int gen_longest;
        int row_len;
        int pick;
        logic [1:0] noise_kind;

        clear_profile();

        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_NEW_SEQ, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "A", 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "Y", 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "a", 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, 8'hFF, 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "W", 12'd0);
        queue_item(apc_pkg::KIND_NEW_SEQ, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "C", 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "Y", 12'd0);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd1);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd2);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd5);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd6);
        queue_item(apc_pkg::KIND_QUERY, 8'hFF, 12'hFFF);
        queue_item(apc_pkg::KIND_NEW_SEQ, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, "#", 12'd0);
        queue_item(apc_pkg::KIND_RESIDUE, ">", 12'd0);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd0);
        pause_next = 1'b1;
        queue_item(apc_pkg::KIND_CLEAR, 8'h00, 12'd0);
        queue_item(apc_pkg::KIND_QUERY, 8'h00, 12'd0);

        random_start = queued_items;
        gen_longest  = 0;
        pause_next   = 1'b1;
        while (queued_items - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 249) == 0) begin
                pause_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                queue_item(apc_pkg::KIND_CLEAR, 8'($urandom), 12'($urandom));
                gen_longest = 0;
            end else if (pick < 10) begin
                noise_kind = 2'($urandom);
                queue_item(noise_kind, 8'($urandom), 12'($urandom));
                if (noise_kind == apc_pkg::KIND_CLEAR) begin
                    gen_longest = 0;
                end
            end else if (pick < 15) begin
                for (int i = $urandom_range(1, 5); i > 0; i--) begin
                    queue_item(apc_pkg::KIND_RESIDUE, pick_residue(), 12'($urandom));
                end
                queue_item(apc_pkg::KIND_QUERY, 8'($urandom),
                           12'($urandom_range(0, gen_longest + 2)));
            end else begin
                row_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
                queue_item(apc_pkg::KIND_NEW_SEQ, 8'($urandom), 12'($urandom));
                for (int i = 0; i < row_len; i++) begin
                    queue_item(apc_pkg::KIND_RESIDUE, pick_residue(), 12'($urandom));
                    if ($urandom_range(0, 29) == 0) begin
                        queue_item(apc_pkg::KIND_QUERY, 8'($urandom),
                                   12'($urandom_range(0, i + 1)));
                    end
                end
                if (row_len > gen_longest) begin
                    gen_longest = row_len;
                end
                for (int i = $urandom_range(1, 3); i > 0; i--) begin
                    if ($urandom_range(0, 9) == 0) begin
                        queue_item(apc_pkg::KIND_QUERY, 8'($urandom), 12'($urandom));
                    end else begin
                        queue_item(apc_pkg::KIND_QUERY, 8'($urandom),
                                   12'($urandom_range(0, gen_longest + 1)));
                    end
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (item_q.size() != 0 || s_valid || consensus_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run took %0d input transactions (%0d table clears) and checked %0d consensus",
                 items_accepted, clears_accepted, results_checked);
        $display("results, covering unknown letters, ties, columns past the profile and noise.");
        if (error_count == 0 && consensus_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
